// ===== hw/rtl/wrre_pkg.sv =====
package wrre_pkg;

    // window of stored angle/time pairs
    localparam int WINDOW_DEPTH = 8;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    // field widths
    localparam int ACC_W   = 16;
    localparam int ANG_W   = 16;
    localparam int TICK_W  = 32;
    localparam int SCALE_W = 32;
    localparam int RATE_W  = 32;
    localparam int PROD_W  = ANG_W + SCALE_W;

    // ring entry: time above angle
    localparam int ENTRY_W = ANG_W + TICK_W;

    // vectoring loop
    localparam int CORDIC_STEPS = 14;
    localparam int SH_W         = $clog2(CORDIC_STEPS);
    localparam int VEC_W        = 27;
    localparam int PRE_SHIFT    = 8;

    // restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [ANG_W-1:0]   HALF_TURN   = ANG_W'(32768);
    localparam logic [RATE_W-1:0]  RATE_MAX    = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0]  RATE_MIN    = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_WRITE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // atan(2^-i) in binary-angle units, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_lut(input logic [SH_W-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            4'd0:    val = 16'd8192;
            4'd1:    val = 16'd4836;
            4'd2:    val = 16'd2555;
            4'd3:    val = 16'd1297;
            4'd4:    val = 16'd651;
            4'd5:    val = 16'd326;
            4'd6:    val = 16'd163;
            4'd7:    val = 16'd81;
            4'd8:    val = 16'd41;
            4'd9:    val = 16'd20;
            4'd10:   val = 16'd10;
            4'd11:   val = 16'd5;
            4'd12:   val = 16'd3;
            4'd13:   val = 16'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/wrre_ram.sv =====
module wrre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/wheel_rotation_rate_estimator.sv =====
// Wheel rotation rate estimator. Each request on the s_ side carries one
// accelerometer reading and a millisecond timestamp and produces exactly one
// request on the m_ side: the wheel angle (binary angle, 65536 per turn, from
// a 14-step CORDIC vectoring loop), and the rate over the window, i.e. the
// wrapped angle change against the oldest of the last WINDOW_DEPTH entries,
// times velocity_scale (Q16.16), divided by the elapsed ms, truncated toward
// zero and saturated. A zero interval gives rate 0 with m_tuser set; a zero
// y reading repeats the previous angle. One request is processed at a time,
// in order: accept, CORDIC, ring write, multiply, divide (skipped when the
// interval is zero) and output load; the restoring divider produces one
// quotient bit per cycle. The output is registered, so a new request is
// accepted while the last result waits. The window lives in a small RAM;
// per-entry valid bits make unwritten entries read as zero right after reset,
// with no clearing pass. The user must write velocity_scale through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module wheel_rotation_rate_estimator (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: velocity_scale
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [15:0] accel_x, [31:16] accel_y, [63:32] tick_ms
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] angular_rate, [47:32] wheel_angle
    output logic [0:0]  m_tuser    // [0] zero_interval
);

    localparam int DEPTH = wrre_pkg::WINDOW_DEPTH;
    localparam int PW    = wrre_pkg::PTR_W;
    localparam int AW    = wrre_pkg::ANG_W;
    localparam int TW    = wrre_pkg::TICK_W;
    localparam int VW    = wrre_pkg::VEC_W;
    localparam int PRW   = wrre_pkg::PROD_W;
    localparam int RW    = wrre_pkg::RATE_W;
    localparam int CW    = wrre_pkg::CNT_W;

    // control state
    wrre_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             rd_vld_reg;
    logic [31:0]      scale_reg, scale_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // payload
    logic signed [VW-1:0] u_reg, u_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic [AW-1:0]        z_reg, z_next;
    logic                 base_reg, base_next;
    logic                 yzero_reg, yzero_next;
    logic [TW-1:0]        tick_reg, tick_next;
    logic [AW-1:0]        prev_ang_reg, prev_ang_next;
    logic [AW-1:0]        ang_reg, ang_next;
    logic                 neg_reg, neg_next;
    logic [AW-1:0]        mag_reg, mag_next;
    logic [TW-1:0]        dt_reg, dt_next;
    logic                 zero_reg, zero_next;
    logic [PRW-1:0]       rq_reg, rq_next;    // dividend shifts out, quotient shifts in
    logic [TW-1:0]        rem_reg, rem_next;
    logic [RW-1:0]        m_rate_reg, m_rate_next;
    logic [AW-1:0]        m_angle_reg, m_angle_next;
    logic                 m_zero_reg, m_zero_next;

    // ring RAM
    logic                          ram_we;
    logic [PW-1:0]                 ram_rd_addr;
    logic [wrre_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic [wrre_pkg::ENTRY_W-1:0]  ram_rd_data;

    wrre_ram #(
        .WIDTH (wrre_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ptr_reg),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next slot after ptr_reg: new pointer while idle, oldest entry afterwards
    logic [PW-1:0] ptr_inc;
    assign ptr_inc = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // shared shift/add step
    logic signed [VW-1:0] sh_u, sh_v;
    logic [AW-1:0]        atan_val;
    assign sh_u     = u_reg >>> cnt_reg[wrre_pkg::SH_W-1:0];
    assign sh_v     = v_reg >>> cnt_reg[wrre_pkg::SH_W-1:0];
    assign atan_val = wrre_pkg::atan_lut(cnt_reg[wrre_pkg::SH_W-1:0]);

    // divider trial subtract
    logic [TW:0] trial;
    logic        trial_ge;
    assign trial    = {rem_reg, rq_reg[PRW-1]};
    assign trial_ge = trial >= {1'b0, dt_reg};

    // oldest entry, zero if never written
    logic [AW-1:0] old_ang;
    logic [TW-1:0] old_tick;
    assign old_ang  = rd_vld_reg ? ram_rd_data[AW-1:0] : '0;
    assign old_tick = rd_vld_reg ? ram_rd_data[AW +: TW] : '0;

    // input fields
    logic signed [wrre_pkg::ACC_W-1:0] in_x, in_y;
    logic signed [VW-1:0]              in_xw, in_yw;
    assign in_x  = s_tdata[15:0];
    assign in_y  = s_tdata[31:16];
    assign in_xw = VW'(in_x);
    assign in_yw = VW'(in_y);

    logic [AW-1:0] ang_w, da_w;
    logic [TW-1:0] dt_w;
    assign ang_w = yzero_reg ? prev_ang_reg
                             : (base_reg ? wrre_pkg::HALF_TURN : '0) + z_reg;
    assign dt_w  = tick_reg - old_tick;
    assign da_w  = ang_w - old_ang;

    assign ram_wr_data = {tick_reg, ang_w};

    logic accept;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        vld_next      = vld_reg;
        scale_next    = scale_reg;
        m_tvalid_next = m_tvalid_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        z_next        = z_reg;
        base_next     = base_reg;
        yzero_next    = yzero_reg;
        tick_next     = tick_reg;
        prev_ang_next = prev_ang_reg;
        ang_next      = ang_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        dt_next       = dt_reg;
        zero_next     = zero_reg;
        rq_next       = rq_reg;
        rem_next      = rem_reg;
        m_rate_next   = m_rate_reg;
        m_angle_next  = m_angle_reg;
        m_zero_next   = m_zero_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_rd_addr   = ptr_inc;

        if (cfg_wr_en) begin
            scale_next = cfg_wr_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            wrre_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                ram_rd_addr = ptr_reg;   // becomes the previous slot
                if (accept) begin
                    ptr_next   = ptr_inc;
                    tick_next  = s_tdata[63:32];
                    yzero_next = (in_y == '0);
                    base_next  = in_y[wrre_pkg::ACC_W-1];
                    u_next     = (in_y[wrre_pkg::ACC_W-1] ? -in_yw : in_yw)
                                 <<< wrre_pkg::PRE_SHIFT;
                    v_next     = (in_y[wrre_pkg::ACC_W-1] ? -in_xw : in_xw)
                                 <<< wrre_pkg::PRE_SHIFT;
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = wrre_pkg::ST_CORDIC;
                end
            end

            wrre_pkg::ST_CORDIC: begin
                if (cnt_reg == '0) begin
                    prev_ang_next = rd_vld_reg ? ram_rd_data[AW-1:0] : '0;
                end
                if (v_reg > 0) begin
                    u_next = u_reg + sh_v;
                    v_next = v_reg - sh_u;
                    z_next = z_reg + atan_val;
                end else begin
                    u_next = u_reg - sh_v;
                    v_next = v_reg + sh_u;
                    z_next = z_reg - atan_val;
                end
                if (cnt_reg == CW'(wrre_pkg::CORDIC_STEPS - 1)) begin
                    state_next = wrre_pkg::ST_WRITE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            wrre_pkg::ST_WRITE: begin
                ram_we            = 1'b1;
                vld_next[ptr_reg] = 1'b1;
                ang_next          = ang_w;
                dt_next           = dt_w;
                zero_next         = (dt_w == '0);
                neg_next          = da_w[AW-1];
                mag_next          = da_w[AW-1] ? -da_w : da_w;
                state_next        = wrre_pkg::ST_MUL;
            end

            wrre_pkg::ST_MUL: begin
                rq_next  = PRW'(mag_reg) * PRW'(scale_reg);
                rem_next = '0;
                cnt_next = '0;
                state_next = zero_reg ? wrre_pkg::ST_OUT : wrre_pkg::ST_DIV;
            end

            wrre_pkg::ST_DIV: begin
                rem_next = trial_ge ? TW'(trial - {1'b0, dt_reg}) : TW'(trial);
                rq_next  = {rq_reg[PRW-2:0], trial_ge};
                if (cnt_reg == CW'(wrre_pkg::DIV_STEPS - 1)) begin
                    state_next = wrre_pkg::ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            wrre_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_angle_next  = ang_reg;
                    m_zero_next   = zero_reg;
                    if (zero_reg) begin
                        m_rate_next = '0;
                    end else if (neg_reg) begin
                        m_rate_next = (rq_reg > PRW'(wrre_pkg::RATE_MIN))
                                      ? wrre_pkg::RATE_MIN : -rq_reg[RW-1:0];
                    end else begin
                        m_rate_next = (rq_reg > PRW'(wrre_pkg::RATE_MAX))
                                      ? wrre_pkg::RATE_MAX : rq_reg[RW-1:0];
                    end
                    state_next = wrre_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = wrre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wrre_pkg::ST_IDLE;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            scale_reg    <= wrre_pkg::SCALE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            vld_reg      <= vld_next;
            rd_vld_reg   <= vld_reg[ram_rd_addr];
            scale_reg    <= scale_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        z_reg        <= z_next;
        base_reg     <= base_next;
        yzero_reg    <= yzero_next;
        tick_reg     <= tick_next;
        prev_ang_reg <= prev_ang_next;
        ang_reg      <= ang_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        dt_reg       <= dt_next;
        zero_reg     <= zero_next;
        rq_reg       <= rq_next;
        rem_reg      <= rem_next;
        m_rate_reg   <= m_rate_next;
        m_angle_reg  <= m_angle_next;
        m_zero_reg   <= m_zero_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_angle_reg, m_rate_reg};
    assign m_tuser  = m_zero_reg;

    // one request in flight: no second accept right behind the first
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while previous one in progress");

    // pointer stays inside the window for non power-of-two depths too
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PW'(DEPTH - 1))
        else $error("write pointer out of window");

    // restoring divider keeps its remainder below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wrre_pkg::ST_DIV) |-> (rem_reg < dt_reg))
        else $error("divider remainder not below interval");

    // zero interval flag only with a zero rate
    a_zero_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_zero_reg) |-> (m_rate_reg == '0))
        else $error("zero interval with nonzero rate");

endmodule

// ===== dv/wheel_rotation_rate_estimator_checker.sv =====
module wheel_rate_checker
    import wrre_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SCALE_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic [0:0]           m_tuser,
    output int unsigned          mismatches,
    output int unsigned          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // atan(2^-i) in binary-angle units
    localparam int ATAN_STEP [CORDIC_STEPS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [ANG_W-1:0]  angle;
        logic              zero_iv;
    } rate_sample_t;

    // window copy and scale
    logic [ANG_W-1:0]   angle_hist [WINDOW_DEPTH];
    logic [TICK_W-1:0]  tick_hist  [WINDOW_DEPTH];
    logic [PTR_W-1:0]   slot;
    logic [SCALE_W-1:0] scale;

    rate_sample_t expected_rates [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // vectoring: angle from the y axis towards x, half turn added for y < 0
    function automatic logic [ANG_W-1:0] tilt_angle(input logic signed [ACC_W-1:0] ax,
                                                    input logic signed [ACC_W-1:0] ay);
        longint u, v, nu;
        int z;
        logic [ANG_W-1:0] base;
        u = ay;
        v = ax;
        z = 0;
        base = '0;
        if (u < 0) begin
            u = -u;
            v = -v;
            base = HALF_TURN;
        end
        u = u * 256;
        v = v * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (v > 0) begin
                nu = u + (v >>> i);
                v  = v - (u >>> i);
                z += ATAN_STEP[i];
            end else begin
                nu = u - (v >>> i);
                v  = v + (u >>> i);
                z -= ATAN_STEP[i];
            end
            u = nu;
        end
        return base + z[ANG_W-1:0];
    endfunction

    // one request: advance the slot, store angle/tick, rate against the oldest
    task automatic advance_window(input logic [63:0] req, output rate_sample_t res);
        logic signed [ACC_W-1:0] ax, ay;
        logic [TICK_W-1:0]       tick, dt;
        logic [ANG_W-1:0]        ang;
        logic signed [ANG_W-1:0] da;
        logic [PTR_W-1:0]        prev, oldest;
        logic [16:0]             da_mag;
        logic [63:0]             quot;
        ax   = req[15:0];
        ay   = req[31:16];
        tick = req[63:32];
        // slot arithmetic wraps at the window depth, power of two or not
        slot   = (slot == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
        prev   = (slot == '0) ? PTR_W'(WINDOW_DEPTH - 1) : slot - 1'b1;
        oldest = (slot == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
        ang = (ay == 0) ? angle_hist[prev] : tilt_angle(ax, ay);
        angle_hist[slot] = ang;
        tick_hist[slot]  = tick;
        dt = tick - tick_hist[oldest];
        da = ang - angle_hist[oldest];
        res.angle   = ang;
        res.zero_iv = (dt == 0);
        res.rate    = '0;
        if (dt != 0) begin
            da_mag = (da < 0) ? 17'(-int'(da)) : 17'(da);
            quot   = (64'(da_mag) * 64'(scale)) / 64'(dt);
            if (da < 0)
                res.rate = (quot > 64'h8000_0000) ? RATE_MIN : RATE_W'(-quot);
            else
                res.rate = (quot > 64'h7FFF_FFFF) ? RATE_MAX : quot[RATE_W-1:0];
        end
    endtask

    always @(posedge aclk) begin : watch
        rate_sample_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                angle_hist[i] = '0;
                tick_hist[i]  = '0;
            end
            slot  = '0;
            scale = SCALE_RESET;
            expected_rates.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en)
                scale = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.rate    = m_tdata[31:0];
                got.angle   = m_tdata[47:32];
                got.zero_iv = m_tuser[0];
                if (expected_rates.size() == 0) begin
                    report_mismatch("unexpected result, rate", got.rate, '0);
                end else begin
                    want = expected_rates.pop_front();
                    if (got.rate !== want.rate)
                        report_mismatch("angular_rate", got.rate, want.rate);
                    if (got.angle !== want.angle)
                        report_mismatch("wheel_angle", 32'(got.angle), 32'(want.angle));
                    if (got.zero_iv !== want.zero_iv)
                        report_mismatch("zero_interval", 32'(got.zero_iv),
                                        32'(want.zero_iv));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_window(s_tdata, want);
                expected_rates.push_back(want);
            end
        end
        outstanding <= expected_rates.size();
    end

endmodule

// ===== dv/wheel_rotation_rate_estimator_tb.sv =====
module wheel_rotation_rate_estimator_tb;

    import wrre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // the drain wait covers one full pass of a request
    localparam int DRAIN_CYCLES = 100;
    // slowest run is roughly 475 requests, each with its processing, stalls and gaps; many times that
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_LEN    = 75;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycles = 0;

    // when set, neither side inserts idle cycles
    logic steady = 1'b0;

    logic [31:0] tick_now = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    wheel_rotation_rate_estimator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    wheel_rate_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure: ~24% stall cycles unless in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 24);
    end

    // One request. Any idle gap starts on the step the previous request was
    // accepted, so tvalid sees a single assignment per step. tvalid is left
    // high on return; the next call either keeps it or drops it for a gap.
    task automatic send_reading(input logic [15:0] ax, input logic [15:0] ay,
                                input logic [31:0] tick);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 24)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tick, ay, ax};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every outstanding result, then one more pass
    // worth of cycles. The first edge lets the counter see the last request.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // scale register is only touched with the block idle
    task automatic write_scale(input logic [31:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1:       return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random requests. Ticks mostly advance by 1 to 50 ms; now and then they
    // freeze for a window's worth (zero interval), jump anywhere, or sit just
    // below the 32-bit wrap.
    task automatic random_phase(input int count);
        logic [15:0] ax, ay;
        int frozen;
        frozen = 0;
        repeat (count) begin
            ax = pick_component();
            ay = ($urandom_range(7) == 0) ? 16'h0000 : pick_component();
            if (frozen > 0) begin
                frozen--;
            end else begin
                case ($urandom_range(29))
                    0:       tick_now = $urandom;
                    1:       tick_now = 32'hFFFF_FFFF - 32'($urandom_range(40));
                    2:       frozen   = $urandom_range(8, 12);
                    3, 4:    ;
                    default: tick_now = tick_now + 32'($urandom_range(1, 50));
                endcase
            end
            send_reading(ax, ay, tick_now);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, reset scale (1.0) ---
        // y zero right after reset: previous angle is the cleared entry, dt 0
        send_reading(16'h0000, 16'h0000, 32'd0);
        // component extremes, both half planes
        send_reading(16'h7FFF, 16'h0001, 32'd1);
        send_reading(16'h8000, 16'h0001, 32'd2);
        send_reading(16'h0000, 16'h7FFF, 32'd3);
        send_reading(16'h0000, 16'h8000, 32'd4);
        send_reading(16'h8000, 16'h8000, 32'd5);
        send_reading(16'h7FFF, 16'h7FFF, 32'd6);
        send_reading(16'hFFFF, 16'hFFFF, 32'd7);
        // y zero again: repeats the last angle
        send_reading(16'h0001, 16'h0000, 32'd7);
        // half-turn difference: straight up, six repeats, then straight down;
        // the last request sees the first as its oldest entry
        send_reading(16'h0000, 16'd100, 32'd20);
        for (int i = 0; i < 6; i++)
            send_reading(16'h0005, 16'h0000, 32'd21 + 32'(i));
        send_reading(16'h0000, -16'sd100, 32'd30);

        // --- directed, maximum scale: products saturate both ways ---
        write_scale(32'hFFFF_FFFF);
        send_reading(16'h7FFF, 16'h0001, 32'd31);
        send_reading(16'h8000, 16'h0001, 32'd32);
        send_reading(16'h7FFF, 16'h0001, 32'd33);
        send_reading(16'h8000, 16'h0001, 32'd34);
        send_reading(16'h0100, 16'h7F00, 32'hFFFF_FFFF);
        send_reading(16'hFF00, 16'h7F00, 32'h0000_0002);
        tick_now = 32'h0000_0002;

        // --- random phases across scale settings ---
        write_scale(32'h0000_0000);
        random_phase(PHASE_LEN);
        write_scale(32'h0000_0001);
        random_phase(PHASE_LEN);
        write_scale($urandom);
        steady = 1'b1;
        random_phase(PHASE_LEN);
        steady = 1'b0;
        write_scale(32'hFFFF_FFFF);
        random_phase(PHASE_LEN);
        write_scale(32'($urandom_range(32'h0010_0000)));
        random_phase(PHASE_LEN);
        write_scale(SCALE_RESET);
        random_phase(PHASE_LEN);

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
